@@ rtl/core/uled_pkg.sv @@
// ----------------------------------------------------------------------------
// uled_pkg
// Shared constants, codes and controller/datapath interface types for the
// terminal line editor.
// ----------------------------------------------------------------------------
package uled_pkg;

    // Line geometry. A line holds at most LINE_MAX-1 bytes.
    localparam int LINE_MAX = 64;
    localparam int LEN_W    = $clog2(LINE_MAX);
    localparam int MEM_AW   = LEN_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    // Characters the editor recognizes or emits.
    localparam logic [7:0] CHR_CR  = 8'h0d;
    localparam logic [7:0] CHR_LF  = 8'h0a;
    localparam logic [7:0] CHR_BS  = 8'h08;
    localparam logic [7:0] CHR_DEL = 8'h7f;
    localparam logic [7:0] CHR_SP  = 8'h20;
    localparam logic [7:0] CHR_O   = 8'h6f;
    localparam logic [7:0] CHR_T   = 8'h74;
    localparam logic [7:0] CHR_NUL = 8'h00;

    // Request kinds.
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result channels.
    typedef logic [1:0] chan_t;
    localparam chan_t CHAN_ECHO = 2'd0;
    localparam chan_t CHAN_LINE = 2'd1;
    localparam chan_t CHAN_END  = 2'd2;

    // Classification of an incoming request.
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_DROP   = 3'd0;
    localparam cls_t CLS_STORE  = 3'd1;
    localparam cls_t CLS_BS     = 3'd2;
    localparam cls_t CLS_EOL    = 3'd3;
    localparam cls_t CLS_LINE   = 3'd4;
    localparam cls_t CLS_NOLINE = 3'd5;

    // Source selection for the output register.
    typedef logic [2:0] src_t;
    localparam src_t SRC_BYTE = 3'd0;
    localparam src_t SRC_BS   = 3'd1;
    localparam src_t SRC_SP   = 3'd2;
    localparam src_t SRC_CR   = 3'd3;
    localparam src_t SRC_LF   = 3'd4;
    localparam src_t SRC_LINE = 3'd5;
    localparam src_t SRC_END  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        src_t src;
        logic last;
        logic rd_issue;
        logic rd_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cls_t cls;
        logic out_free;
        logic rd_end;
    } stat_t;

endpackage

@@ rtl/core/uled_ctrl.sv @@
// ----------------------------------------------------------------------------
// uled_ctrl
// Sequencer for the line editor: accepts one request at a time and steps
// through the results that request causes.
// ----------------------------------------------------------------------------
module uled_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  uled_pkg::stat_t stat,
    output uled_pkg::cmd_t  cmd
);
    import uled_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ECHO = 4'd1;
    localparam logic [3:0] S_BS1  = 4'd2;
    localparam logic [3:0] S_BS2  = 4'd3;
    localparam logic [3:0] S_BS3  = 4'd4;
    localparam logic [3:0] S_CR   = 4'd5;
    localparam logic [3:0] S_LF   = 4'd6;
    localparam logic [3:0] S_RDA  = 4'd7;
    localparam logic [3:0] S_RDD  = 4'd8;
    localparam logic [3:0] S_END  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load     = 1'b0;
        cmd.src      = SRC_BYTE;
        cmd.last     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.rd_step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    case (stat.cls)
                        CLS_STORE:  state_next = S_ECHO;
                        CLS_BS:     state_next = S_BS1;
                        CLS_EOL:    state_next = S_CR;
                        CLS_LINE:   state_next = S_RDA;
                        CLS_NOLINE: state_next = S_END;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ECHO:
            begin
                cmd.src  = SRC_BYTE;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BS1:
            begin
                cmd.src = SRC_BS;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BS2;
                end
            end
            S_BS2:
            begin
                cmd.src = SRC_SP;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BS3;
                end
            end
            S_BS3:
            begin
                cmd.src  = SRC_BS;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CR:
            begin
                cmd.src = SRC_CR;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LF;
                end
            end
            S_LF:
            begin
                cmd.src  = SRC_LF;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Issue a line memory read, or finish when the line is exhausted.
            S_RDA:
            begin
                if (stat.rd_end)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RDD;
                end
            end
            // Hand the registered read data to the output register.
            S_RDD:
            begin
                cmd.src = SRC_LINE;
                if (stat.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.rd_step = 1'b1;
                    state_next  = S_RDA;
                end
            end
            S_END:
            begin
                cmd.src  = SRC_END;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/uled_dp.sv @@
// ----------------------------------------------------------------------------
// uled_dp
// Datapath of the line editor: two line buffers in one memory that swap
// roles on publish, lengths, pending flag and the output register.
// ----------------------------------------------------------------------------
module uled_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 kind,
    input  logic [7:0]           rx_byte,
    input  uled_pkg::cmd_t       cmd,
    output uled_pkg::stat_t      stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           channel,
    output logic [7:0]           data,
    output logic                 line_valid,
    output logic                 line_published,
    output logic                 last
);
    import uled_pkg::*;

    // Line memory: half selected by wsel_reg is the work line, the other
    // half holds the ready line.
    logic [7:0]        mem [0:MEM_DEPTH-1];
    logic [7:0]        rd_q;

    logic [LEN_W-1:0]  wlen_reg;
    logic [LEN_W-1:0]  wlen_next;
    logic [LEN_W-1:0]  rlen_reg;
    logic [LEN_W-1:0]  rlen_next;
    logic [LEN_W-1:0]  rd_idx_reg;
    logic [LEN_W-1:0]  rd_idx_next;
    logic              pend_reg;
    logic              pend_next;
    logic              wsel_reg;
    logic              wsel_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [7:0]        whead_reg [0:2];
    logic [7:0]        rhead_reg [0:2];
    logic [7:0]        byte_reg;
    logic              pub_reg;
    logic              lv_reg;

    logic [1:0]        chan_reg;
    logic [7:0]        data_reg;
    logic              lv_out_reg;
    logic              pub_out_reg;
    logic              last_reg;

    cls_t              cls;
    logic [LEN_W-1:0]  start;
    logic              mem_we;
    logic [MEM_AW-1:0] waddr;
    logic [MEM_AW-1:0] raddr;
    logic [1:0]        chan_mux;
    logic [7:0]        data_mux;
    logic              lv_mux;
    logic              pub_mux;
    logic              load;

    // Classify the offered request.
    always_comb
    begin
        if (kind == KIND_READ)
        begin
            cls = pend_reg ? CLS_LINE : CLS_NOLINE;
        end
        else if (rx_byte == CHR_CR || rx_byte == CHR_LF)
        begin
            cls = CLS_EOL;
        end
        else if (rx_byte == CHR_BS || rx_byte == CHR_DEL)
        begin
            cls = (wlen_reg != '0) ? CLS_BS : CLS_DROP;
        end
        else if (wlen_reg < LEN_W'(LINE_MAX - 1))
        begin
            cls = CLS_STORE;
        end
        else
        begin
            cls = CLS_DROP;
        end
    end

    // First byte emitted: skip a leading "ot " or a bare "ot".
    always_comb
    begin
        start = '0;
        if (rlen_reg >= LEN_W'(2) && rhead_reg[0] == CHR_O && rhead_reg[1] == CHR_T)
        begin
            if (rlen_reg == LEN_W'(2))
            begin
                start = LEN_W'(2);
            end
            else if (rhead_reg[2] == CHR_SP)
            begin
                start = LEN_W'(3);
            end
        end
    end

    assign load          = cmd.load;
    assign stat.cls      = cls;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.rd_end   = (rd_idx_reg == rlen_reg);

    // Control register updates.
    always_comb
    begin
        wlen_next   = wlen_reg;
        rlen_next   = rlen_reg;
        rd_idx_next = rd_idx_reg;
        pend_next   = pend_reg;
        wsel_next   = wsel_reg;
        if (cmd.accept)
        begin
            case (cls)
                CLS_STORE:
                begin
                    wlen_next = wlen_reg + LEN_W'(1);
                end
                CLS_BS:
                begin
                    wlen_next = wlen_reg - LEN_W'(1);
                end
                CLS_EOL:
                begin
                    if (!pend_reg)
                    begin
                        rlen_next = wlen_reg;
                        wlen_next = '0;
                        pend_next = 1'b1;
                        wsel_next = ~wsel_reg;
                    end
                end
                CLS_LINE:
                begin
                    pend_next   = 1'b0;
                    rd_idx_next = start;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + LEN_W'(1);
        end
    end

    // Output register handshake.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= '0;
            rlen_reg      <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            wsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            rlen_reg      <= rlen_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            wsel_reg      <= wsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-request payload: echo byte, publish and delivery flags, line head.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= rx_byte;
            pub_reg  <= (cls == CLS_EOL) && !pend_reg;
            lv_reg   <= (cls == CLS_LINE);
            if (cls == CLS_STORE && wlen_reg < LEN_W'(3))
            begin
                whead_reg[wlen_reg[1:0]] <= rx_byte;
            end
            if (cls == CLS_EOL && !pend_reg)
            begin
                rhead_reg[0] <= whead_reg[0];
                rhead_reg[1] <= whead_reg[1];
                rhead_reg[2] <= whead_reg[2];
            end
        end
    end

    // Line memory: one write port, one registered read port.
    assign mem_we = cmd.accept && (cls == CLS_STORE);
    assign waddr  = {wsel_reg, wlen_reg};
    assign raddr  = {~wsel_reg, rd_idx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_q <= mem[raddr];
        end
    end

    // Select the next result.
    always_comb
    begin
        chan_mux = CHAN_ECHO;
        data_mux = CHR_NUL;
        lv_mux   = 1'b0;
        pub_mux  = 1'b0;
        case (cmd.src)
            SRC_BYTE: data_mux = byte_reg;
            SRC_BS:   data_mux = CHR_BS;
            SRC_SP:   data_mux = CHR_SP;
            SRC_CR:   data_mux = CHR_CR;
            SRC_LF:
            begin
                data_mux = CHR_LF;
                pub_mux  = pub_reg;
            end
            SRC_LINE:
            begin
                chan_mux = CHAN_LINE;
                data_mux = rd_q;
            end
            SRC_END:
            begin
                chan_mux = CHAN_END;
                lv_mux   = lv_reg;
            end
            default:
            begin
                data_mux = CHR_NUL;
            end
        endcase
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg    <= chan_mux;
            data_reg    <= data_mux;
            lv_out_reg  <= lv_mux;
            pub_out_reg <= pub_mux;
            last_reg    <= cmd.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel        = chan_reg;
    assign data           = data_reg;
    assign line_valid     = lv_out_reg;
    assign line_published = pub_out_reg;
    assign last           = last_reg;

endmodule

@@ rtl/core/uart_line_editor_top.sv @@
// Each result of an accepted request is loaded into the output register once it is free;
// for a pending line, each line byte is first read through the registered memory port.
// Throughput: one request at a time; a new request is taken only after the last result of
// the previous one is loaded. A dropped byte causes no result and leaves the editor idle.
// Reset clears lengths, pending flag and control state; line memory is not cleared.
// ----------------------------------------------------------------------------
// uart_line_editor_top
// Terminal line editor with echo: stores received bytes, handles backspace
// and end of line, and delivers the pending line on request.
// ----------------------------------------------------------------------------
module uart_line_editor_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] channel,
    output logic [7:0] data,
    output logic       line_valid,
    output logic       line_published,
    output logic       last
);
    import uled_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    uled_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uled_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel        (channel),
        .data           (data),
        .line_valid     (line_valid),
        .line_published (line_published),
        .last           (last)
    );

    // The end marker always closes the response to a request.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel == CHAN_END |-> last)
        else $error("end marker without last");

    // A publish is flagged only on the final LF echo.
    a_pub_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_published |-> channel == CHAN_ECHO && data == CHR_LF && last)
        else $error("publish flag outside final LF echo");

    // Line delivery is reported only on the end marker.
    a_lv_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_valid |-> channel == CHAN_END)
        else $error("line_valid outside end marker");

    // Line bytes are never the final result of a request.
    a_line_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel == CHAN_LINE |-> !last)
        else $error("line byte marked last");

endmodule

@@ tb/uart_line_editor_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_editor_top_tb
// Self-checking bench for the terminal line editor. Requests are received
// bytes and line reads. A short directed run covers the corner cases. Random
// lines follow: optional command prefixes, backspaces, overlong lines and
// stray requests. Every result is checked against a behavioral line editor.
// Both handshakes stall at random.
// ----------------------------------------------------------------------------
module uart_line_editor_top_tb;

    import uled_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 252;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } edit_req_t;

    typedef struct packed {
        chan_t      channel;
        logic [7:0] data;
        logic       line_valid;
        logic       line_published;
        logic       last;
    } editor_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       kind = KIND_RX;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] channel;
    logic [7:0] data;
    logic       line_valid;
    logic       line_published;
    logic       last;

    // Request stream and the editor output it should produce.
    edit_req_t   req_q[$];
    editor_out_t editor_out_q[$];

    // Behavioral copy of the editor state.
    logic [7:0] work_buf[LINE_MAX];
    logic [6:0] work_len;
    logic [7:0] ready_buf[LINE_MAX];
    logic [6:0] ready_len;
    logic       line_held;

    int req_total;
    int req_sent;
    int req_done;
    int results_seen;
    int lines_delivered;
    int mismatch_cnt;
    int cycle_cnt;
    logic calm;

    uart_line_editor_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel        (channel),
        .data           (data),
        .line_valid     (line_valid),
        .line_published (line_published),
        .last           (last)
    );

    always #5 clk = ~clk;

    // A window of requests during which neither side ever stalls.
    assign calm = (req_sent >= 120) && (req_sent < 180);

    task automatic push_out(input chan_t ch, input logic [7:0] d, input logic lv,
                            input logic pub);
        editor_out_t r;
        r.channel        = ch;
        r.data           = d;
        r.line_valid     = lv;
        r.line_published = pub;
        r.last           = 1'b0;
        editor_out_q.push_back(r);
    endtask

    // Apply one request to the editor state and queue the output it causes.
    task automatic edit_line(input logic k, input logic [7:0] c);
        int   n0;
        int   start;
        logic pub;
        n0  = editor_out_q.size();
        pub = 1'b0;
        if (k == KIND_RX) begin
            if (c == CHR_CR || c == CHR_LF) begin
                // End of line publishes the work line unless one is still unread.
                if (!line_held) begin
                    for (int i = 0; i < work_len; i++)
                        ready_buf[i] = work_buf[i];
                    ready_len = work_len;
                    work_len  = '0;
                    line_held = 1'b1;
                    pub       = 1'b1;
                end
                push_out(CHAN_ECHO, CHR_CR, 1'b0, 1'b0);
                push_out(CHAN_ECHO, CHR_LF, 1'b0, pub);
            end
            else if (c == CHR_BS || c == CHR_DEL) begin
                if (work_len > 0) begin
                    work_len = work_len - 1'b1;
                    push_out(CHAN_ECHO, CHR_BS, 1'b0, 1'b0);
                    push_out(CHAN_ECHO, CHR_SP, 1'b0, 1'b0);
                    push_out(CHAN_ECHO, CHR_BS, 1'b0, 1'b0);
                end
            end
            else if (work_len < LINE_MAX - 1) begin
                work_buf[work_len] = c;
                work_len = work_len + 1'b1;
                push_out(CHAN_ECHO, c, 1'b0, 1'b0);
            end
        end
        else if (line_held) begin
            // Strip a leading "ot " or a bare "ot" from the delivered line.
            start = 0;
            if (ready_len >= 2 && ready_buf[0] == CHR_O && ready_buf[1] == CHR_T) begin
                if (ready_len == 2)
                    start = 2;
                else if (ready_buf[2] == CHR_SP)
                    start = 3;
            end
            for (int i = start; i < ready_len; i++)
                push_out(CHAN_LINE, ready_buf[i], 1'b0, 1'b0);
            line_held = 1'b0;
            push_out(CHAN_END, CHR_NUL, 1'b1, 1'b0);
        end
        else begin
            push_out(CHAN_END, CHR_NUL, 1'b0, 1'b0);
        end
        if (editor_out_q.size() > n0)
            editor_out_q[editor_out_q.size() - 1].last = 1'b1;
    endtask

    task automatic add_req(input logic k, input logic [7:0] c);
        edit_req_t r;
        r.kind    = k;
        r.rx_byte = c;
        req_q.push_back(r);
        req_total++;
    endtask

    task automatic add_read();
        add_req(KIND_READ, 8'($urandom_range(0, 255)));
    endtask

    // Driver: offers the next request, holding it until it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                edit_line(kind, rx_byte);
                req_done++;
            end
            if (!in_valid || in_ready)
            begin
                if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20))
                begin
                    in_valid <= 1'b1;
                    kind     <= req_q[0].kind;
                    rx_byte  <= req_q[0].rx_byte;
                    req_q.pop_front();
                    req_sent <= req_sent + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the output at random and checks every accepted result.
    always @(posedge clk)
    begin
        editor_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (editor_out_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("ERROR: unexpected result ch=%0d data=%02h lv=%b pub=%b last=%b",
                                 channel, data, line_valid, line_published, last);
                end
                else
                begin
                    want = editor_out_q.pop_front();
                    if (want.channel == CHAN_END && want.line_valid)
                        lines_delivered++;
                    if (channel !== want.channel || data !== want.data ||
                        line_valid !== want.line_valid ||
                        line_published !== want.line_published || last !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"ERROR: result %0d expected ch=%0d data=%02h lv=%b ",
                                      "pub=%b last=%b, got ch=%0d data=%02h lv=%b pub=%b last=%b"},
                                     results_seen, want.channel, want.data, want.line_valid,
                                     want.line_published, want.last, channel, data,
                                     line_valid, line_published, last);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d requests done",
                     cycle_cnt, req_done, req_total);
            $display("uart_line_editor_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int gen_cnt;
        int len;
        int pfx;
        int sel;
        logic [7:0] c;

        work_len  = '0;
        ready_len = '0;
        line_held = 1'b0;
        req_total = 0;
        req_sent  = 0;
        req_done  = 0;
        results_seen = 0;
        lines_delivered = 0;
        mismatch_cnt = 0;
        cycle_cnt = 0;

        // Directed part: empty reads and erases, empty and prefixed lines,
        // extreme byte values, and an end of line while a line is unread.
        add_read();
        add_req(KIND_RX, CHR_BS);
        add_req(KIND_RX, CHR_DEL);
        add_req(KIND_RX, CHR_CR);
        add_read();
        add_req(KIND_RX, CHR_O);
        add_req(KIND_RX, CHR_T);
        add_req(KIND_RX, CHR_LF);
        add_read();
        add_req(KIND_RX, CHR_O);
        add_req(KIND_RX, CHR_T);
        add_req(KIND_RX, CHR_SP);
        add_req(KIND_RX, CHR_NUL);
        add_req(KIND_RX, 8'hff);
        add_req(KIND_RX, CHR_CR);
        add_req(KIND_RX, 8'h61);
        add_req(KIND_RX, CHR_DEL);
        add_req(KIND_RX, 8'h62);
        add_req(KIND_RX, CHR_BS);
        add_req(KIND_RX, CHR_O);
        add_req(KIND_RX, CHR_T);
        add_req(KIND_RX, 8'h78);
        add_req(KIND_RX, CHR_LF);
        add_read();
        add_req(KIND_RX, CHR_CR);
        add_read();

        // Random part: mostly complete lines followed by a read.
        gen_cnt = 0;
        while (gen_cnt < RANDOM_REQS)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                gen_cnt++;
            end
            else
            begin
                if ($urandom_range(0, 14) == 0)
                    len = $urandom_range(60, 72);
                else
                    len = $urandom_range(0, 10);
                pfx = $urandom_range(0, 9);
                if (pfx <= 2)
                begin
                    add_req(KIND_RX, CHR_O);
                    add_req(KIND_RX, CHR_T);
                    add_req(KIND_RX, CHR_SP);
                    gen_cnt += 3;
                end
                else if (pfx == 3)
                begin
                    add_req(KIND_RX, CHR_O);
                    add_req(KIND_RX, CHR_T);
                    gen_cnt += 2;
                    len = 0;
                end
                else if (pfx == 4)
                begin
                    add_req(KIND_RX, CHR_O);
                    add_req(KIND_RX, CHR_T);
                    gen_cnt += 2;
                end
                else if (pfx == 5)
                begin
                    add_req(KIND_RX, CHR_O);
                    gen_cnt++;
                end
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (len <= 10 && $urandom_range(0, 9) == 0)
                        c = $urandom_range(0, 1) ? CHR_BS : CHR_DEL;
                    add_req(KIND_RX, c);
                    // Bytes past a full line are dropped and do not count.
                    if (i < LINE_MAX - 1)
                        gen_cnt++;
                end
                add_req(KIND_RX, $urandom_range(0, 1) ? CHR_CR : CHR_LF);
                gen_cnt++;
                sel = $urandom_range(0, 99);
                if (sel < 85)
                begin
                    add_read();
                    gen_cnt++;
                end
                if (sel >= 95)
                begin
                    add_read();
                    add_read();
                    gen_cnt += 2;
                end
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every result to arrive.
        while (req_done < req_total || editor_out_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests, checked %0d results, %0d lines delivered, %0d cycles",
                 req_done, results_seen, lines_delivered, cycle_cnt);
        $display("Mismatches: %0d, results still awaited: %0d",
                 mismatch_cnt, editor_out_q.size());
        if (mismatch_cnt == 0 && editor_out_q.size() == 0)
            $display("uart_line_editor_top verification clean");
        else
            $display("uart_line_editor_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/uled_pkg.sv
rtl/core/uled_ctrl.sv
rtl/core/uled_dp.sv
rtl/core/uart_line_editor_top.sv
tb/uart_line_editor_top_tb.sv
